/* sv/clv_pkg.sv */
`default_nettype none

package clv_pkg;

  // Field and register widths.
  localparam int unsigned CARD_W = 63;
  localparam int unsigned CFG_W  = 5;

  // Decimal capacity of a card number and the longest number the block accepts.
  localparam int unsigned CARD_DIGITS    = 19;
  localparam int unsigned MAX_DEC_DIGITS = 19;

  // Binary to BCD conversion: the binary word is padded to a whole number of steps.
  localparam int unsigned BCD_W      = 4 * CARD_DIGITS;
  localparam int unsigned CONV_BITS  = 4;
  localparam int unsigned BIN_W      = 64;
  localparam int unsigned CONV_STEPS = BIN_W / CONV_BITS;
  localparam int unsigned STEP_W     = $clog2(CONV_STEPS);
  localparam int unsigned POS_W      = $clog2(CARD_DIGITS);
  localparam int unsigned CNT_W      = $clog2(CARD_DIGITS + 1);

  // Register reset values.
  localparam logic [CFG_W-1:0] MIN_DIGITS_RST = 5'd13;
  localparam logic [CFG_W-1:0] MAX_DIGITS_RST = 5'd16;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_DIGITS = 1'b0;
  localparam logic REG_MAX_DIGITS = 1'b1;

  // Accepted leading digits; the two-digit prefix is three followed by seven.
  localparam logic [3:0] LEAD_FOUR  = 4'd4;
  localparam logic [3:0] LEAD_FIVE  = 4'd5;
  localparam logic [3:0] LEAD_SIX   = 4'd6;
  localparam logic [3:0] LEAD_THREE = 4'd3;
  localparam logic [3:0] LEAD_SEVEN = 4'd7;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_LEN    = 2'd1,
    STAT_PREFIX = 2'd2,
    STAT_LUHN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] min_digits;
    logic [CFG_W-1:0] max_digits;
  } cfg_t;

  // One double-dabble step: correct every digit of five or more, then shift one bit in.
  function automatic logic [BCD_W-1:0] bcd_step(input logic [BCD_W-1:0] bcd,
                                                input logic shift_in);
    logic [BCD_W-1:0] adj;
    for (int k = 0; k < CARD_DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd[4*k +: 4];
      end
    end
    return {adj[BCD_W-2:0], shift_in};
  endfunction

  // Luhn contribution of one digit; doubled digits fold back to their digit sum.
  function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic dbl);
    logic [4:0] dd;
    dd = {1'b0, d};
    if (dbl) begin
      dd = {d, 1'b0};
      if (dd >= 5'd10) begin
        dd = dd - 5'd9;
      end
    end
    return dd[3:0];
  endfunction

  // True when every nibble of a BCD word is a decimal digit.
  function automatic logic all_dec(input logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < CARD_DIGITS; k++) begin
      if (bcd[4*k +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* sv/clv_if.sv */
`default_nettype none

// Card number channel.
interface clv_in_if;
  import clv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

// Check result channel.
interface clv_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [1:0] status;

  modport source (output valid, output valid_res, output status, input ready);
  modport sink (input valid, input valid_res, input status, output ready);
endinterface

`default_nettype wire

/* sv/clv_engine.sv */
`default_nettype none

module clv_engine (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  clv_pkg::cfg_t cfg_i,
  clv_in_if.sink        in_if,
  clv_out_if.source     out_if
);
  import clv_pkg::*;

  state_e              state_q, state_d;
  logic [BIN_W-1:0]    bin_q;
  logic [BCD_W-1:0]    bcd_q;
  logic [STEP_W-1:0]   step_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [3:0]          lead_q;
  logic                is37_q;
  logic [3:0]          prev_q;
  logic [3:0]          sum_q;
  logic                out_valid_q;
  logic                out_valid_res_q;
  status_e             out_status_q;

  logic                in_fire;
  logic                conv_last;
  logic                scan_last;
  logic                out_load;
  logic                out_free;
  logic [BCD_W-1:0]    conv_bcd;
  logic [3:0]          digit;
  logic [3:0]          term;
  logic [4:0]          sum_raw;
  logic [3:0]          sum_next;
  status_e             status;

  assign in_fire   = in_if.valid && in_if.ready;
  assign conv_last = (step_q == STEP_W'(CONV_STEPS - 1));
  assign scan_last = (pos_q == POS_W'(CARD_DIGITS - 1));
  assign out_free  = !out_valid_q || out_if.ready;

  // Shared conversion unit: four double-dabble steps per cycle.
  always_comb begin
    conv_bcd = bcd_q;
    for (int k = 0; k < CONV_BITS; k++) begin
      conv_bcd = bcd_step(conv_bcd, bin_q[BIN_W-1-k]);
    end
  end

  // Digit scan unit: Luhn term and running sum modulo ten.
  assign digit    = bcd_q[3:0];
  assign term     = luhn_term(digit, pos_q[0]);
  assign sum_raw  = {1'b0, sum_q} + {1'b0, term};
  assign sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

  // Final checks in priority order: length, prefix, Luhn sum.
  always_comb begin
    if (cnt_q > CNT_W'(MAX_DEC_DIGITS) ||
        CFG_W'(cnt_q) < cfg_i.min_digits || CFG_W'(cnt_q) > cfg_i.max_digits) begin
      status = STAT_LEN;
    end else if (!(lead_q == LEAD_FOUR || lead_q == LEAD_FIVE ||
                   lead_q == LEAD_SIX || is37_q)) begin
      status = STAT_PREFIX;
    end else if (sum_q != 4'd0) begin
      status = STAT_LUHN;
    end else begin
      status = STAT_OK;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    in_if.ready = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        step_q <= '0;
      end else if (state_q == ST_CONV) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == ST_CONV) begin
        pos_q <= '0;
      end else if (state_q == ST_SCAN) begin
        pos_q <= pos_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bin_q  <= {1'b0, in_if.card_number};
      bcd_q  <= '0;
      cnt_q  <= '0;
      lead_q <= '0;
      is37_q <= 1'b0;
      prev_q <= '0;
      sum_q  <= '0;
    end else if (state_q == ST_CONV) begin
      bin_q <= {bin_q[BIN_W-CONV_BITS-1:0], {CONV_BITS{1'b0}}};
      bcd_q <= conv_bcd;
    end else if (state_q == ST_SCAN) begin
      bcd_q  <= {4'd0, bcd_q[BCD_W-1:4]};
      sum_q  <= sum_next;
      prev_q <= digit;
      if (digit != 4'd0) begin
        cnt_q  <= CNT_W'(pos_q) + 1'b1;
        lead_q <= digit;
        is37_q <= (digit == LEAD_THREE) && (prev_q == LEAD_SEVEN);
      end
    end
    if (out_load) begin
      out_status_q    <= status;
      out_valid_res_q <= (status == STAT_OK);
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.valid_res = out_valid_res_q;
  assign out_if.status    = out_status_q;

  // An accepted number always starts the conversion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_CONV)
    else $error("accepted beat did not start conversion");

  // The conversion leaves only decimal digits for the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> all_dec(bcd_q))
    else $error("non-decimal digit during scan");

  // The digit count never exceeds the decimal capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> cnt_q <= CNT_W'(CARD_DIGITS))
    else $error("digit count out of range");

  // A new result only follows the hold state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_HOLD))
    else $error("result loaded outside hold state");

endmodule

`default_nettype wire

/* sv/card_number_luhn_validator_top.sv */
// Card number checker: length, leading digits and Luhn mod-10 sum.
// Input channel in_if carries one card number per beat as an unsigned
// 63-bit integer; output channel out_if carries one result per beat with
// valid_res and a status code (0 valid, 1 bad length, 2 bad prefix,
// 3 Luhn sum failed). Both use valid/ready.
// An APB write sets min_digits (address 0) or max_digits (address 4);
// writes must be made while the block is idle; the block does not enforce it.
// An accepted number passes through binary-to-BCD conversion (four
// bits a cycle through the shared correct-and-shift logic), a scan of
// every decimal digit, one digit a cycle, through the Luhn accumulator,
// and the final checks in the hold state as the result is loaded. The
// block then returns to idle and can take the next number; it takes no
// new number while one is being converted or scanned.
// The result sits in an output register; a new number is accepted while
// it waits. If the receiver still stalls when the next result is ready,
// the block holds it and takes no new number until the register frees.
// Reset clears the sequencer and the output valid, and sets min_digits to
// 13 and max_digits to 16.
`default_nettype none

module card_number_luhn_validator_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  clv_in_if.sink      in_if,
  clv_out_if.source   out_if
);
  import clv_pkg::*;

  cfg_t cfg_q;
  logic reg_idx;
  logic reg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_digits <= MIN_DIGITS_RST;
      cfg_q.max_digits <= MAX_DIGITS_RST;
    end else if (reg_write) begin
      case (reg_idx)
        REG_MIN_DIGITS: cfg_q.min_digits <= pwdata[CFG_W-1:0];
        REG_MAX_DIGITS: cfg_q.max_digits <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_MIN_DIGITS: prdata = {{(32-CFG_W){1'b0}}, cfg_q.min_digits};
      REG_MAX_DIGITS: prdata = {{(32-CFG_W){1'b0}}, cfg_q.max_digits};
      default:        prdata = '0;
    endcase
  end

  clv_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

`default_nettype wire
